// File: rtl/lzhc_pkg.sv
// Shared constants, types and a helper function for the LZ77 hash chain insert core.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package lzhc_pkg;

  // Table geometry.
  localparam int HASH_W      = 15;
  localparam int HASH_SPAN   = 3;
  localparam int WIN_SIZE    = 32768;
  localparam int HASH_SHIFT  = (HASH_W + HASH_SPAN - 1) / HASH_SPAN;
  localparam int HEAD_DEPTH  = 1 << HASH_W;
  localparam int WIN_AW      = $clog2(WIN_SIZE);
  localparam int SWEEP_AW    = (HASH_W > WIN_AW) ? HASH_W : WIN_AW;
  localparam int SWEEP_DEPTH = 1 << SWEEP_AW;

  // Fixed field widths.
  localparam int POS_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int OUT_HASH_W = 15;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SLIDE  = 1'b1
  } lzhc_cmd_t;

  // One classified word as it travels through the queue.
  typedef struct packed {
    lzhc_cmd_t         cmd;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
  } lzhc_item_t;

  // Status that the back end reports to the front end.
  typedef struct packed {
    logic clearing;
  } lzhc_stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SLIDE,
    ST_SLIDE_END
  } lzhc_state_t;

  // Move a stored position down by one window; positions inside the old window become 0.
  function automatic logic [POS_W-1:0] rebase(input logic [POS_W-1:0] v);
    logic [POS_W:0] win;
    win = (POS_W + 1)'(WIN_SIZE);
    if ({1'b0, v} >= win) begin
      rebase = POS_W'({1'b0, v} - win);
    end else begin
      rebase = '0;
    end
  endfunction

endpackage

// File: rtl/lzhc_front.sv
// Front end of the hash chain core: takes command words, keeps the rolling hash
// and pushes classified words into the queue. Depends on lzhc_pkg.
module lzhc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [lzhc_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [lzhc_pkg::POS_W-1:0]   in_position,
  input  lzhc_pkg::lzhc_stat_t         stat,
  input  logic                         q_ready,
  output logic                         q_push,
  output lzhc_pkg::lzhc_item_t         q_push_item
);

  logic [lzhc_pkg::HASH_W-1:0] rolling_hash_r;
  logic [lzhc_pkg::HASH_W-1:0] rolling_hash_nxt;
  logic [lzhc_pkg::HASH_W-1:0] hash_upd;
  lzhc_pkg::lzhc_cmd_t         cmd;

  assign cmd  = lzhc_pkg::lzhc_cmd_t'(in_command);
  assign busy = !q_ready || stat.clearing;

  always_comb begin
    hash_upd = lzhc_pkg::HASH_W'({rolling_hash_r, {lzhc_pkg::HASH_SHIFT{1'b0}}})
               ^ lzhc_pkg::HASH_W'(in_data_byte);
    q_push   = start && !busy;
    rolling_hash_nxt = rolling_hash_r;
    if (q_push && (cmd == lzhc_pkg::CMD_INSERT)) begin
      rolling_hash_nxt = hash_upd;
    end
    q_push_item.cmd  = cmd;
    q_push_item.hash = (cmd == lzhc_pkg::CMD_INSERT) ? hash_upd : rolling_hash_r;
    q_push_item.pos  = in_position;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rolling_hash_r <= '0;
    end else begin
      rolling_hash_r <= rolling_hash_nxt;
    end
  end

endmodule

// File: rtl/lzhc_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on lzhc_pkg for the word type and depth.
module lzhc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lzhc_pkg::lzhc_item_t  push_item,
  output logic                  ready,
  input  logic                  pop,
  output logic                  head_valid,
  output lzhc_pkg::lzhc_item_t  head_item
);

  lzhc_pkg::lzhc_item_t          entry_r [lzhc_pkg::QUEUE_DEPTH];
  logic [lzhc_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [lzhc_pkg::QUEUE_AW-1:0] wr_ptr_nxt;
  logic [lzhc_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [lzhc_pkg::QUEUE_AW-1:0] rd_ptr_nxt;
  logic [lzhc_pkg::QUEUE_AW:0]   count_r;
  logic [lzhc_pkg::QUEUE_AW:0]   count_nxt;

  assign ready      = (count_r != (lzhc_pkg::QUEUE_AW + 1)'(lzhc_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == lzhc_pkg::QUEUE_AW'(lzhc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == lzhc_pkg::QUEUE_AW'(lzhc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/lzhc_back.sv
// Back end of the hash chain core: owns the head and prev tables, runs the
// clearing pass, the insert pipeline and the slide sweep. Depends on lzhc_pkg.
module lzhc_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  lzhc_pkg::lzhc_item_t             q_item,
  output logic                             q_pop,
  output lzhc_pkg::lzhc_stat_t             stat,
  output logic                             out_valid,
  output logic [lzhc_pkg::POS_W-1:0]       out_match_head,
  output logic [lzhc_pkg::OUT_HASH_W-1:0]  out_hash_value
);

  localparam int HW  = lzhc_pkg::HASH_W;
  localparam int WAW = lzhc_pkg::WIN_AW;
  localparam int SAW = lzhc_pkg::SWEEP_AW;
  localparam int PW  = lzhc_pkg::POS_W;
  localparam logic [SAW:0]   HEAD_LIMIT = (SAW + 1)'(lzhc_pkg::HEAD_DEPTH);
  localparam logic [SAW:0]   WIN_LIMIT  = (SAW + 1)'(lzhc_pkg::WIN_SIZE);
  localparam logic [SAW-1:0] SWEEP_LAST = SAW'(lzhc_pkg::SWEEP_DEPTH - 1);

  // Tables.
  logic [PW-1:0] head_mem [lzhc_pkg::HEAD_DEPTH];
  logic [PW-1:0] prev_mem [lzhc_pkg::WIN_SIZE];

  logic           head_we;
  logic [HW-1:0]  head_waddr;
  logic [PW-1:0]  head_wdata;
  logic [HW-1:0]  head_raddr;
  logic [PW-1:0]  head_rdata_r;
  logic           prev_we;
  logic [WAW-1:0] prev_waddr;
  logic [PW-1:0]  prev_wdata;
  logic [WAW-1:0] prev_raddr;
  logic [PW-1:0]  prev_rdata_r;

  // Control.
  lzhc_pkg::lzhc_state_t state_r;
  lzhc_pkg::lzhc_state_t state_nxt;
  logic [SAW-1:0]        cnt_r;
  logic [SAW-1:0]        cnt_nxt;

  // Insert stage after the head read, and the write it made last cycle.
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  lzhc_pkg::lzhc_item_t  s1_item_r;
  logic                  fwd_valid_r;
  logic [HW-1:0]         fwd_hash_r;
  logic [PW-1:0]         fwd_pos_r;
  logic [PW-1:0]         old_head;

  // Slide sweep write stage.
  logic                  sw_valid_r;
  logic                  sw_valid_nxt;
  logic [SAW-1:0]        sw_addr_r;

  // Result registers.
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [PW-1:0]                 out_match_head_r;
  logic [PW-1:0]                 out_match_head_nxt;
  logic [lzhc_pkg::OUT_HASH_W-1:0] out_hash_value_r;
  logic [lzhc_pkg::OUT_HASH_W-1:0] out_hash_value_nxt;

  assign out_valid      = out_valid_r;
  assign out_match_head = out_match_head_r;
  assign out_hash_value = out_hash_value_r;
  assign stat.clearing  = (state_r == lzhc_pkg::ST_CLEAR);

  // The read issued together with the previous insert's write saw the old head.
  assign old_head = (fwd_valid_r && (fwd_hash_r == s1_item_r.hash)) ? fwd_pos_r : head_rdata_r;

  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    q_pop              = 1'b0;
    s1_valid_nxt       = 1'b0;
    sw_valid_nxt       = 1'b0;
    out_valid_nxt      = 1'b0;
    out_match_head_nxt = old_head;
    out_hash_value_nxt = lzhc_pkg::OUT_HASH_W'(s1_item_r.hash);
    head_raddr         = q_item.hash;
    prev_raddr         = cnt_r[WAW-1:0];

    head_we    = 1'b0;
    head_waddr = s1_item_r.hash;
    head_wdata = s1_item_r.pos;
    prev_we    = 1'b0;
    prev_waddr = s1_item_r.pos[WAW-1:0];
    prev_wdata = old_head;

    case (state_r)
      lzhc_pkg::ST_CLEAR: begin
        head_we    = ({1'b0, cnt_r} < HEAD_LIMIT);
        head_waddr = cnt_r[HW-1:0];
        head_wdata = '0;
        prev_we    = ({1'b0, cnt_r} < WIN_LIMIT);
        prev_waddr = cnt_r[WAW-1:0];
        prev_wdata = '0;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == SWEEP_LAST) begin
          state_nxt = lzhc_pkg::ST_RUN;
        end
      end
      lzhc_pkg::ST_RUN: begin
        if (q_valid) begin
          if (q_item.cmd == lzhc_pkg::CMD_INSERT) begin
            q_pop        = 1'b1;
            s1_valid_nxt = 1'b1;
          end else if (!s1_valid_r) begin
            q_pop     = 1'b1;
            cnt_nxt   = '0;
            state_nxt = lzhc_pkg::ST_SLIDE;
          end
        end
        if (s1_valid_r) begin
          head_we       = 1'b1;
          prev_we       = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      lzhc_pkg::ST_SLIDE: begin
        head_raddr   = cnt_r[HW-1:0];
        sw_valid_nxt = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == SWEEP_LAST) begin
          state_nxt = lzhc_pkg::ST_SLIDE_END;
        end
      end
      lzhc_pkg::ST_SLIDE_END: begin
        out_valid_nxt      = 1'b1;
        out_match_head_nxt = '0;
        out_hash_value_nxt = '0;
        state_nxt          = lzhc_pkg::ST_RUN;
      end
      default: begin
        state_nxt = lzhc_pkg::ST_RUN;
      end
    endcase

    // Write back the rebased entry that was read in the previous cycle.
    if (sw_valid_r) begin
      head_we    = ({1'b0, sw_addr_r} < HEAD_LIMIT);
      head_waddr = sw_addr_r[HW-1:0];
      head_wdata = lzhc_pkg::rebase(head_rdata_r);
      prev_we    = ({1'b0, sw_addr_r} < WIN_LIMIT);
      prev_waddr = sw_addr_r[WAW-1:0];
      prev_wdata = lzhc_pkg::rebase(prev_rdata_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzhc_pkg::ST_CLEAR;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      sw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= s1_valid_r;
      sw_valid_r  <= sw_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
    end
    fwd_hash_r       <= s1_item_r.hash;
    fwd_pos_r        <= s1_item_r.pos;
    sw_addr_r        <= cnt_r;
    out_match_head_r <= out_match_head_nxt;
    out_hash_value_r <= out_hash_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata_r <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rdata_r <= prev_mem[prev_raddr];
  end

  // Nothing leaves the queue while the tables are being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzhc_pkg::ST_CLEAR) |-> !q_pop)
    else $error("word taken from queue during clearing pass");

  // Sweep writes and insert writes never share the write ports.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && sw_valid_r))
    else $error("insert and sweep write in the same cycle");

  // The end of a slide produces one all-zero result.
  a_slide_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzhc_pkg::ST_SLIDE_END) |=>
      (out_valid_r && (out_match_head_r == '0) && (out_hash_value_r == '0)))
    else $error("slide result missing or not zero");

  // Back-to-back inserts on the same hash chain through the forwarded head.
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_valid_r && (fwd_hash_r == s1_item_r.hash)) |=>
      (out_valid_r && (out_match_head_r == $past(fwd_pos_r))))
    else $error("forwarded head not returned");

endmodule

// File: rtl/lz77_hash_chain_insert_core.sv
// Deflate LZ77 hash chain insert core: rolling hash, head table and prev chain table.
// An accepted insert passes the queue, the s1 stage after the head read and the result
// registers before out_valid rises; a slide sweeps all 32768 table rows, one per cycle,
// then returns one all-zero result. Insert words are taken one per cycle while no slide
// or clearing pass runs. After rst_n the block clears both tables with busy high.
// The receiver cannot stall. Depends on lzhc_pkg, lzhc_front, lzhc_queue and lzhc_back.
module lz77_hash_chain_insert_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_command,
  input  logic [lzhc_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic [lzhc_pkg::POS_W-1:0]       in_position,
  output logic                             out_valid,
  output logic [lzhc_pkg::POS_W-1:0]       out_match_head,
  output logic [lzhc_pkg::OUT_HASH_W-1:0]  out_hash_value
);

  // The front end takes a word whenever the queue has room and the tables are not
  // being cleared. It updates the rolling hash for inserts at that edge, so the hash
  // sequence follows the accepted word order even when the back end is behind.
  //
  // In the run state the back end pops inserts one per cycle: the head table is read
  // with the new hash, and in the next cycle the position is written as the new head,
  // the old head is linked into the prev table and returned. When two inserts in a row
  // hit the same hash, the head written by the first is forwarded to the second.
  //
  // A slide waits for the insert pipeline to drain, then reads every row of both
  // tables and writes each back rebased in the next cycle. Words that arrive during a
  // sweep wait in the queue; busy rises once it is full.

  lzhc_pkg::lzhc_stat_t stat;
  lzhc_pkg::lzhc_item_t push_item;
  lzhc_pkg::lzhc_item_t head_item;
  logic                 q_ready;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;

  lzhc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_position  (in_position),
    .stat         (stat),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_push_item  (push_item)
  );

  lzhc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  lzhc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (head_item),
    .q_pop          (q_pop),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_match_head (out_match_head),
    .out_hash_value (out_hash_value)
  );

endmodule
